// ===== hdl/id3v2_frame_text_extractor_macros.svh =====
// Assertion macros for the ID3v2 frame text extractor.
// Expects clk and arst_n in the scope of each use.
`ifndef ID3V2_FRAME_TEXT_EXTRACTOR_MACROS_SVH
`define ID3V2_FRAME_TEXT_EXTRACTOR_MACROS_SVH

// same-cycle implication
`define ID3FX_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ID3FX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/id3fx_pkg.sv =====
// Shared types, codes and helper functions of the ID3v2 frame text extractor.
// No dependencies.
package id3fx_pkg;

	typedef enum logic [1:0] {
		PH_HDR,
		PH_FHDR,
		PH_PAYLOAD,
		PH_DONE
	} phase_t;

	localparam logic [2:0] FIELD_TITLE  = 3'd0;
	localparam logic [2:0] FIELD_ARTIST = 3'd1;
	localparam logic [2:0] FIELD_GENRE  = 3'd2;
	localparam logic [2:0] FIELD_BPM    = 3'd3;
	localparam logic [2:0] FIELD_KEY    = 3'd4;
	localparam logic [2:0] FIELD_NONE   = 3'd7;

	localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
	localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
	localparam logic [31:0] ID_TCON = 32'h5443_4F4E;
	localparam logic [31:0] ID_TBPM = 32'h5442_504D;
	localparam logic [31:0] ID_TKEY = 32'h544B_4559;

	localparam logic [7:0] CHAR_LOW  = 8'd32;
	localparam logic [7:0] CHAR_HIGH = 8'd127;
	localparam logic [3:0] HDR_LAST  = 4'd9;
	localparam logic [28:0] HDR_LEN  = 29'd10;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_of_file;
	} in_item_t;

	typedef struct packed {
		logic [2:0] field_code;
		logic [6:0] char_code;
		logic       char_valid;
		logic       value_end;
		logic       value_abandoned;
	} out_item_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		logic [7:0] m;
		case (idx)
			2'd0: m = 8'h49;
			2'd1: m = 8'h44;
			2'd2: m = 8'h33;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	function automatic logic [2:0] field_of_ident(input logic [31:0] id);
		logic [2:0] f;
		case (id)
			ID_TIT2: f = FIELD_TITLE;
			ID_TPE1: f = FIELD_ARTIST;
			ID_TCON: f = FIELD_GENRE;
			ID_TBPM: f = FIELD_BPM;
			ID_TKEY: f = FIELD_KEY;
			default: f = FIELD_NONE;
		endcase
		return f;
	endfunction

endpackage

// ===== hdl/id3fx_in_reg.sv =====
// Input register stage of the ID3v2 frame text extractor.
// Depends on id3fx_pkg.
module id3fx_in_reg
	import id3fx_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     valid,
	output logic     stall,
	input  in_item_t item,
	input  logic     adv,
	output logic     valid_s1,
	output in_item_t item_s1
);

	logic vld_s1;

	assign stall    = vld_s1 && !adv;
	assign valid_s1 = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!stall) begin
			vld_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall && valid) begin
			item_s1 <= item;
		end
	end

endmodule

// ===== hdl/id3fx_parser.sv =====
// Tag and frame header parser with text extraction for one byte per cycle while adv is high.
// Depends on id3fx_pkg and the assertion macro header.
`include "id3v2_frame_text_extractor_macros.svh"
module id3fx_parser
	import id3fx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  in_item_t  item,
	output logic      res_valid,
	output out_item_t res
);

	phase_t      phase_q, phase_n;
	logic [3:0]  hcnt_q, hcnt_n;
	logic [27:0] tag_len_q, tag_len_n;
	logic [31:0] pos_q, pos_n;
	logic [31:0] ident_q, ident_n;
	logic [27:0] flen_q, flen_n;
	logic [27:0] rem_q, rem_n;
	logic [2:0]  field_q, field_n;
	logic        stop_q, stop_n;
	logic        cv;
	logic        tag_over;
	logic [7:0]  b;

	assign b        = item.data_byte;
	assign tag_over = pos_q >= {3'b000, HDR_LEN + {1'b0, tag_len_q}};

	always_comb begin
		phase_n   = phase_q;
		hcnt_n    = hcnt_q;
		tag_len_n = tag_len_q;
		pos_n     = pos_q + 32'd1;
		ident_n   = ident_q;
		flen_n    = flen_q;
		rem_n     = rem_q;
		field_n   = field_q;
		stop_n    = stop_q;
		cv        = 1'b0;
		case (phase_q)
			PH_HDR: begin
				if (hcnt_q < 4'd3 && b != magic_byte(hcnt_q[1:0])) begin
					phase_n = PH_DONE;
				end else begin
					if (hcnt_q >= 4'd6) begin
						tag_len_n = {tag_len_q[20:0], b[6:0]};
					end
					if (hcnt_q >= HDR_LAST) begin
						hcnt_n  = 4'd0;
						phase_n = PH_FHDR;
					end else begin
						hcnt_n = hcnt_q + 4'd1;
					end
				end
			end
			PH_FHDR: begin
				if (hcnt_q == 4'd0 && (tag_over || b == 8'd0)) begin
					phase_n = PH_DONE;
				end else begin
					if (hcnt_q < 4'd4) begin
						ident_n = {ident_q[23:0], b};
					end else if (hcnt_q < 4'd8) begin
						flen_n = {flen_q[20:0], b[6:0]};
					end
					if (hcnt_q >= HDR_LAST) begin
						hcnt_n  = 4'd0;
						field_n = field_of_ident(ident_q);
						stop_n  = 1'b0;
						if (flen_q != 28'd0) begin
							rem_n   = flen_q;
							phase_n = PH_PAYLOAD;
						end
					end else begin
						hcnt_n = hcnt_q + 4'd1;
					end
				end
			end
			PH_PAYLOAD: begin
				rem_n = rem_q - 28'd1;
				if (field_q != FIELD_NONE && rem_q != flen_q && !stop_q) begin
					if (b == 8'd0) begin
						stop_n = 1'b1;
					end else if (b >= CHAR_LOW && b < CHAR_HIGH) begin
						cv = 1'b1;
					end
				end
				if (rem_n == 28'd0) begin
					phase_n = PH_FHDR;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res_valid = 1'b0;
		res       = '{field_code: field_n, char_code: 7'd0, char_valid: 1'b0,
			value_end: 1'b0, value_abandoned: 1'b0};
		case (phase_q)
			PH_FHDR: begin
				if (hcnt_q >= HDR_LAST && flen_q == 28'd0 && field_n != FIELD_NONE) begin
					res_valid     = 1'b1;
					res.value_end = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				if (rem_n == 28'd0) begin
					res_valid      = field_q != FIELD_NONE;
					res.value_end  = 1'b1;
					res.char_valid = cv;
					res.char_code  = cv ? b[6:0] : 7'd0;
				end else if (cv) begin
					res_valid      = 1'b1;
					res.char_valid = 1'b1;
					res.char_code  = b[6:0];
				end
			end
			default: begin
			end
		endcase
		if (item.last_of_file && phase_n == PH_PAYLOAD && field_n != FIELD_NONE) begin
			res_valid           = 1'b1;
			res.char_code       = 7'd0;
			res.char_valid      = 1'b0;
			res.value_end       = 1'b0;
			res.value_abandoned = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR;
			hcnt_q    <= 4'd0;
			tag_len_q <= 28'd0;
			pos_q     <= 32'd0;
			ident_q   <= 32'd0;
			flen_q    <= 28'd0;
			rem_q     <= 28'd0;
			field_q   <= 3'd0;
			stop_q    <= 1'b0;
		end else if (adv) begin
			if (item.last_of_file) begin
				phase_q   <= PH_HDR;
				hcnt_q    <= 4'd0;
				tag_len_q <= 28'd0;
				pos_q     <= 32'd0;
				ident_q   <= 32'd0;
				flen_q    <= 28'd0;
				rem_q     <= 28'd0;
				field_q   <= 3'd0;
				stop_q    <= 1'b0;
			end else begin
				phase_q   <= phase_n;
				hcnt_q    <= hcnt_n;
				tag_len_q <= tag_len_n;
				pos_q     <= pos_n;
				ident_q   <= ident_n;
				flen_q    <= flen_n;
				rem_q     <= rem_n;
				field_q   <= field_n;
				stop_q    <= stop_n;
			end
		end
	end

	`ID3FX_ASSERT_NEXT(a_eof_resets, adv && item.last_of_file,
		phase_q == PH_HDR && hcnt_q == 4'd0 && pos_q == 32'd0, "state not cleared after end of file")
	`ID3FX_ASSERT_NEXT(a_done_holds, adv && !item.last_of_file && phase_q == PH_DONE,
		phase_q == PH_DONE, "parser left the done phase before end of file")
	`ID3FX_ASSERT_NOW(a_abandon_eof, res_valid && res.value_abandoned,
		item.last_of_file && !res.char_valid && !res.value_end, "abandon without end of file")
	`ID3FX_ASSERT_NOW(a_char_zero, res_valid && !res.char_valid,
		res.char_code == 7'd0, "character code set without a character")

endmodule

// ===== hdl/id3fx_out_reg.sv =====
// Result register of the ID3v2 frame text extractor; holds an item under stall.
// Depends on id3fx_pkg.
module id3fx_out_reg
	import id3fx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  out_item_t load_item,
	output logic      valid,
	input  logic      stall,
	output out_item_t item
);

	logic vld_q;

	assign valid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (!stall) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item <= load_item;
		end
	end

endmodule

// ===== hdl/id3v2_frame_text_extractor.sv =====
// ID3v2 frame text extractor, top level.
// Depends on id3fx_pkg, id3fx_in_reg, id3fx_parser and id3fx_out_reg.
//
// Usage:
//   byte_valid / byte_stall / byte_item carry the file one byte per item, from
//   offset zero; last_of_file marks the final byte and returns the parser to
//   the tag header phase for the next file.
//   text_valid / text_stall / text_item carry the extracted characters, each
//   tagged with its field code, plus value end and value abandoned marks.
//   Most bytes give no result item.
// Timing:
//   One byte is accepted per cycle while byte_stall is low. A byte is held in
//   the input register, and its result, if any, is loaded into the result
//   register when the parse step advances, which raises text_valid.
//   The parse step is counter and compare logic on the state registers, so
//   the rate is one byte per cycle while the receiver takes results.
// Reset and stall:
//   arst_n clears all parser state and both valid flags at once.
//   While a result waits under text_stall, the byte in the input register
//   waits too and byte_stall rises once that register is full.
module id3v2_frame_text_extractor
	import id3fx_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_item_t  byte_item,
	output logic      text_valid,
	input  logic      text_stall,
	output out_item_t text_item
);

	logic      adv;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      res_valid;
	out_item_t res;

	assign adv = valid_s1 && (!text_valid || !text_stall);

	id3fx_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (byte_valid),
		.stall    (byte_stall),
		.item     (byte_item),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	id3fx_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	id3fx_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && res_valid),
		.load_item (res),
		.valid     (text_valid),
		.stall     (text_stall),
		.item      (text_item)
	);

endmodule

// ===== tb/tb_id3v2_frame_text_extractor.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the ID3v2 frame text extractor: drives whole files
// byte by byte, predicts the extracted text items and compares each one on arrival.
// Depends on id3fx_pkg and the id3v2_frame_text_extractor RTL.
module tb_id3v2_frame_text_extractor
	import id3fx_pkg::*;
();

	typedef enum logic [1:0] {
		FEED_BYTE,
		FEED_HOLD,
		FEED_DRAIN
	} feed_kind_t;

	typedef struct {
		feed_kind_t kind;
		in_item_t   item;
	} feed_t;

	localparam logic [23:0] TAG_MAGIC = "ID3";
	localparam logic [31:0] ID_ALBUM  = "TALB";
	localparam int TAIL_ITEMS = 150;
	localparam int HOLD_CYCLES = 200;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_item_t  byte_item = '0;
	logic      text_valid;
	logic      text_stall = 1'b0;
	out_item_t text_item;

	feed_t       byte_feed[$];
	out_item_t   text_expect[$];
	logic [7:0]  fbytes[$];
	feed_t       next_feed;
	out_item_t   pred_res;
	out_item_t   want;

	phase_t      parse_state;
	logic [3:0]  hdr_cnt;
	logic [27:0] tag_len;
	logic [31:0] pos;
	logic [31:0] frame_id;
	logic [27:0] flen;
	logic [27:0] remaining;
	logic [2:0]  cur_field;
	bit          stopped;

	bit          byte_took = 1'b0;
	bit          in_tail = 1'b0;
	int          send_gap = 0;
	int          send_quiet = 0;
	int          recv_gap = 0;
	int          recv_quiet = 0;
	int          hold_left = 0;
	int          holds_asked = 0;
	int          holds_done = 0;
	int unsigned errors = 0;
	int unsigned stim_bytes = 0;
	int unsigned files_sent = 0;
	int unsigned chars_seen = 0;
	int unsigned values_done = 0;
	int unsigned values_dropped = 0;

	id3v2_frame_text_extractor DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_item  (text_item)
	);

	always #5 clk = ~clk;

	function automatic void clear_parse();
		parse_state = PH_HDR;
		hdr_cnt = '0;
		tag_len = '0;
		pos = '0;
		frame_id = '0;
		flen = '0;
		remaining = '0;
		cur_field = '0;
		stopped = 1'b0;
	endfunction

	function automatic logic [2:0] ident_field(input logic [31:0] id);
		if (id == ID_TIT2) return FIELD_TITLE;
		if (id == ID_TPE1) return FIELD_ARTIST;
		if (id == ID_TCON) return FIELD_GENRE;
		if (id == ID_TBPM) return FIELD_BPM;
		if (id == ID_TKEY) return FIELD_KEY;
		return FIELD_NONE;
	endfunction

	function automatic out_item_t text_result(input logic [7:0] b, input bit is_char,
			input bit is_end, input bit is_cut);
		out_item_t r;
		r.field_code = cur_field;
		r.char_code = is_char ? b[6:0] : 7'd0;
		r.char_valid = is_char;
		r.value_end = is_end;
		r.value_abandoned = is_cut;
		return r;
	endfunction

	function automatic bit parse_byte(input in_item_t it, output out_item_t res);
		logic [7:0] b;
		logic [3:0] k;
		bit got;
		bit enc_byte;
		bit printable;
		b = it.data_byte;
		k = hdr_cnt;
		got = 1'b0;
		printable = 1'b0;
		res = '0;
		case (parse_state)
			PH_HDR: begin
				if (k < 4'd3 && b != TAG_MAGIC[8 * (2 - int'(k)) +: 8]) begin
					parse_state = PH_DONE;
				end else begin
					if (k >= 4'd6)
						tag_len = {tag_len[20:0], b[6:0]};
					if (k >= HDR_LAST) begin
						hdr_cnt = '0;
						parse_state = PH_FHDR;
					end else begin
						hdr_cnt = k + 4'd1;
					end
				end
			end
			PH_FHDR: begin
				if (k == 4'd0 && (pos >= 32'd10 + 32'(tag_len) || b == 8'd0)) begin
					parse_state = PH_DONE;
				end else begin
					if (k < 4'd4)
						frame_id = {frame_id[23:0], b};
					else if (k < 4'd8)
						flen = {flen[20:0], b[6:0]};
					if (k >= HDR_LAST) begin
						hdr_cnt = '0;
						cur_field = ident_field(frame_id);
						stopped = 1'b0;
						if (flen == '0) begin
							if (cur_field != FIELD_NONE) begin
								res = text_result(8'd0, 1'b0, 1'b1, 1'b0);
								got = 1'b1;
							end
						end else begin
							remaining = flen;
							parse_state = PH_PAYLOAD;
						end
					end else begin
						hdr_cnt = k + 4'd1;
					end
				end
			end
			PH_PAYLOAD: begin
				enc_byte = (remaining == flen);
				remaining = remaining - 28'd1;
				if (cur_field != FIELD_NONE && !enc_byte && !stopped) begin
					if (b == 8'd0)
						stopped = 1'b1;
					else if (b >= CHAR_LOW && b < CHAR_HIGH)
						printable = 1'b1;
				end
				if (remaining == '0) begin
					if (cur_field != FIELD_NONE) begin
						res = text_result(b, printable, 1'b1, 1'b0);
						got = 1'b1;
					end
					parse_state = PH_FHDR;
				end else if (printable) begin
					res = text_result(b, 1'b1, 1'b0, 1'b0);
					got = 1'b1;
				end
			end
			default: ;
		endcase
		pos = pos + 32'd1;
		if (it.last_of_file) begin
			if (parse_state == PH_PAYLOAD && cur_field != FIELD_NONE) begin
				res = text_result(8'd0, 1'b0, 1'b0, 1'b1);
				got = 1'b1;
			end
			clear_parse();
		end
		return got;
	endfunction

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	task automatic push_file();
		feed_t f;
		f.kind = FEED_BYTE;
		foreach (fbytes[i]) begin
			f.item.data_byte = fbytes[i];
			f.item.last_of_file = (i == fbytes.size() - 1);
			byte_feed.push_back(f);
		end
		stim_bytes += fbytes.size();
		files_sent++;
	endtask

	task automatic push_marker(input feed_kind_t k);
		feed_t f;
		f.kind = k;
		f.item = '0;
		byte_feed.push_back(f);
	endtask

	function automatic logic [7:0] synch_byte(input int unsigned v, input int i);
		return {1'($urandom_range(0, 5) == 0), 7'(v >> (7 * i))};
	endfunction

	function automatic logic [7:0] text_byte();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 15) return 8'($urandom_range(32, 126));
		if (r == 15) return 8'd0;
		if (r == 16) return 8'd127;
		if (r == 17) return 8'd31;
		return 8'($urandom());
	endfunction

	function automatic logic [31:0] pick_ident();
		case ($urandom_range(0, 9))
			0, 1: return ID_TIT2;
			2: return ID_TPE1;
			3: return ID_TCON;
			4: return ID_TBPM;
			5, 6: return ID_TKEY;
			7: return ID_ALBUM;
			8: return ID_TKEY ^ (32'd1 << $urandom_range(0, 31));
			default: return $urandom();
		endcase
	endfunction

	// tag with random frames and tag size; broken ones are cut at a random point and sometimes get a bad magic
	task automatic gen_tag(input bit whole);
		int unsigned nfr;
		int unsigned sz;
		int unsigned tsz;
		int unsigned body_len;
		int unsigned r;
		int unsigned cut;
		logic [31:0] id;
		fbytes.delete();
		for (int i = 2; i >= 0; i--)
			fbytes.push_back(TAG_MAGIC[8 * i +: 8]);
		fbytes.push_back(8'($urandom_range(2, 4)));
		fbytes.push_back(8'($urandom()));
		fbytes.push_back(8'($urandom()));
		repeat (4) fbytes.push_back(8'd0);
		nfr = $urandom_range(1, 4);
		repeat (nfr) begin
			id = pick_ident();
			for (int i = 3; i >= 0; i--)
				fbytes.push_back(id[8 * i +: 8]);
			r = $urandom_range(0, 49);
			if (r < 5) sz = 0;
			else if (r < 10) sz = 1;
			else if (r < 44) sz = $urandom_range(2, 12);
			else if (r < 49) sz = $urandom_range(13, 40);
			else sz = $urandom_range(128, 160);
			for (int i = 3; i >= 0; i--)
				fbytes.push_back(synch_byte(sz, i));
			fbytes.push_back(8'($urandom()));
			fbytes.push_back(8'($urandom()));
			if (sz > 0) begin
				fbytes.push_back(8'($urandom_range(0, 3)));
				repeat (sz - 1) fbytes.push_back(text_byte());
			end
		end
		repeat ($urandom_range(0, 3)) fbytes.push_back(8'd0);
		body_len = fbytes.size() - 10;
		r = $urandom_range(0, 9);
		if (r < 6) tsz = body_len;
		else if (r < 8) tsz = $urandom_range(0, body_len);
		else if (r == 8) tsz = body_len + $urandom_range(1, 30);
		else tsz = $urandom_range(0, 1) ? 0 : 32'h0FFF_FFFF;
		for (int i = 0; i < 4; i++)
			fbytes[6 + i] = synch_byte(tsz, 3 - i);
		repeat ($urandom_range(0, 6)) fbytes.push_back(8'($urandom()));
		if (!whole) begin
			if ($urandom_range(0, 3) == 0) begin
				r = $urandom_range(0, 2);
				fbytes[r] = fbytes[r] ^ (8'd1 << $urandom_range(0, 7));
			end
			cut = $urandom_range(1, fbytes.size());
			while (fbytes.size() > cut)
				void'(fbytes.pop_back());
		end
		push_file();
	endtask

	task automatic gen_noise();
		fbytes.delete();
		if ($urandom_range(0, 1))
			for (int i = 2; i >= 0; i--)
				fbytes.push_back(TAG_MAGIC[8 * i +: 8]);
		repeat ($urandom_range(1, 16)) fbytes.push_back(8'($urandom()));
		push_file();
	endtask

	always @(negedge clk) begin
		if (arst_n && !(byte_valid && !byte_took)) begin
			if (send_quiet > 0)
				send_quiet--;
			else if ($urandom_range(0, 39) == 0)
				send_quiet = $urandom_range(20, 120);
			if (send_gap > 0) begin
				send_gap--;
				byte_valid <= 1'b0;
			end else if (byte_feed.size() == 0) begin
				byte_valid <= 1'b0;
			end else if (byte_feed[0].kind == FEED_DRAIN) begin
				if (text_expect.size() == 0)
					void'(byte_feed.pop_front());
				byte_valid <= 1'b0;
			end else if (byte_feed[0].kind == FEED_HOLD) begin
				void'(byte_feed.pop_front());
				holds_asked <= holds_asked + 1;
				byte_valid <= 1'b0;
			end else if (!in_tail && send_quiet == 0 && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(0, 18);
				byte_valid <= 1'b0;
			end else begin
				next_feed = byte_feed.pop_front();
				byte_item <= next_feed.item;
				byte_valid <= 1'b1;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (recv_quiet > 0)
				recv_quiet--;
			else if ($urandom_range(0, 39) == 0)
				recv_quiet = $urandom_range(20, 120);
			if (hold_left > 0) begin
				hold_left--;
				text_stall <= 1'b1;
			end else if (holds_done != holds_asked) begin
				holds_done++;
				hold_left = HOLD_CYCLES - 1;
				text_stall <= 1'b1;
			end else if (recv_gap > 0) begin
				recv_gap--;
				text_stall <= 1'b1;
			end else if (!in_tail && recv_quiet == 0 && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 18);
				text_stall <= 1'b1;
			end else begin
				text_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			byte_took <= byte_valid && !byte_stall;
			in_tail <= byte_feed.size() < TAIL_ITEMS;
			if (byte_valid && !byte_stall) begin
				if (parse_byte(byte_item, pred_res))
					text_expect.push_back(pred_res);
			end
			if (text_valid && !text_stall) begin
				if (text_expect.size() == 0) begin
					$error("text item %h arrived with nothing pending", text_item);
					errors++;
				end else begin
					want = text_expect.pop_front();
					check_field("field_code", want.field_code, text_item.field_code);
					check_field("char_code", want.char_code, text_item.char_code);
					check_field("char_valid", want.char_valid, text_item.char_valid);
					check_field("value_end", want.value_end, text_item.value_end);
					check_field("value_abandoned", want.value_abandoned,
						text_item.value_abandoned);
					chars_seen += want.char_valid;
					values_done += want.value_end;
					values_dropped += want.value_abandoned;
				end
			end
		end
	end

	initial begin
		int unsigned pick;
		int unsigned next_mark;
		bit hold_turn;
		clear_parse();

		// one-byte file with a bad magic, then a tag whose title runs into the file end
		fbytes = '{8'hFF};
		push_file();
		fbytes = '{8'h49, 8'h44, 8'h33, 8'h04, 8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h7F,
			ID_TIT2[31:24], ID_TIT2[23:16], ID_TIT2[15:8], ID_TIT2[7:0],
			8'h00, 8'h00, 8'h00, 8'h05, 8'hFF, 8'h00,
			8'h03, 8'h20, 8'h7E, 8'h7F};
		push_file();

		next_mark = 300;
		hold_turn = 1'b1;
		while (stim_bytes < 1400) begin
			if (stim_bytes >= next_mark) begin
				push_marker(hold_turn ? FEED_HOLD : FEED_DRAIN);
				if (hold_turn)
					gen_tag(1'b1);
				hold_turn = !hold_turn;
				next_mark += 300;
			end
			pick = $urandom_range(0, 19);
			if (pick < 14)
				gen_tag(1'b1);
			else if (pick < 17)
				gen_tag(1'b0);
			else
				gen_noise();
		end

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		while (byte_feed.size() != 0 || byte_valid)
			@(posedge clk);
		while (text_expect.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d files, %0d bytes, through tag headers, frame walks and cut-off files.",
			files_sent, stim_bytes);
		$display("Checked %0d characters, %0d finished values, %0d abandoned values.",
			chars_seen, values_done, values_dropped);
		if (errors == 0)
			$display("tb_id3v2_frame_text_extractor: PASS");
		else
			$display("tb_id3v2_frame_text_extractor: FAIL");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timed out with %0d items still expected.", text_expect.size());
		$display("tb_id3v2_frame_text_extractor: FAIL");
		$finish;
	end

endmodule

// ===== id3v2_frame_text_extractor.f =====
+incdir+hdl
hdl/id3fx_pkg.sv
hdl/id3fx_in_reg.sv
hdl/id3fx_parser.sv
hdl/id3fx_out_reg.sv
hdl/id3v2_frame_text_extractor.sv
tb/tb_id3v2_frame_text_extractor.sv
